FILE: sv/ftrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftrm_pkg
// Shared types and constants for the fan tachometer rpm meter.
// ----------------------------------------------------------------------------
package ftrm_pkg;

  // Item kinds on the input channel
  localparam logic CMD_PULSE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_SECONDS = 1'b1;
  localparam int unsigned CFG_DATA_W = 16;

  // Field widths
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned SEC_W  = 8;
  localparam int unsigned RPM_W  = 16;

  // Dividend is (count / 2) * 60, which fits in 21 bits
  localparam int unsigned DIVD_W    = 21;
  localparam int unsigned DIV_STEPS = DIVD_W;
  localparam int unsigned STEP_W    = 5;

  localparam logic [TICK_W-1:0] PERIOD_TICKS_RST   = 16'd100;
  localparam logic [SEC_W-1:0]  PERIOD_SECONDS_RST = 8'd1;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic pulse;        // count a tach pulse
    logic tick_adv;     // advance the period counter
    logic period_done;  // clear period counter, select fan 0
    logic div_load;     // load divider for the selected fan
    logic div_step;     // one restoring divide step
    logic emit;         // load output register, clear fan counter
    logic next_fan;     // select the following fan
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic period_end;   // a tick now would end the period
    logic out_free;     // output register can take a word
    logic last_fan;     // selected fan is the last one
  } dp_status_t;

endpackage

FILE: sv/fan_tach_rpm_meter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_tach_rpm_meter_core
// Per-fan tach pulse counting with rpm report for every fan at period end.
// ----------------------------------------------------------------------------
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, cmd_i, fan_i             | into block
//  out     | out_valid_o, out_stall_i, fan_id_o, rpm_o,       | out of block
//          | pulse_count_o, last_o                            |
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | into block
//
//  A tick that ends the period walks every fan in turn: a load, the
//  DIV_STEPS steps of the bit-serial restoring divider, then an emit.
//  Emit waits while the output register holds an untaken word.
//  Reset clears counters and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module fan_tach_rpm_meter_core #(
  parameter int unsigned FAN_COUNT = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             cmd_i,
  input  logic                             fan_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             fan_id_o,
  output logic [ftrm_pkg::RPM_W-1:0]       rpm_o,
  output logic [ftrm_pkg::CNT_W-1:0]       pulse_count_o,
  output logic                             last_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ftrm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ftrm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import ftrm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_we;

  // Registers are only written while idle
  assign cfg_ready_o = !in_stall_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  ftrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (cmd_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ftrm_dp #(
    .FAN_COUNT (FAN_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_we),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fan_i         (fan_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .fan_id_o      (fan_id_o),
    .rpm_o         (rpm_o),
    .pulse_count_o (pulse_count_o),
    .last_o        (last_o)
  );

`ifndef SYNTHESIS
  // Emit never overwrites a word still waiting on the output
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || !out_stall_i))
    else $error("emit while output word pending");

  // A finished period blocks new input words
  a_period_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.period_done |=> in_stall_o)
    else $error("input not stalled after period end");

  // After the last fan is emitted the block takes input again
  a_last_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && status.last_fan) |=> (!in_stall_o && out_valid_o && last_o))
    else $error("no release after last fan");
`endif

endmodule

FILE: sv/ftrm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftrm_ctrl
// Sequencer: takes input words, walks each fan through load, divide, emit.
// ----------------------------------------------------------------------------
module ftrm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_cmd_i,
  output logic                   in_stall_o,
  input  ftrm_pkg::dp_status_t   status_i,
  output ftrm_pkg::ctrl_cmd_t    cmd_o
);
  import ftrm_pkg::*;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd_i == CMD_PULSE) begin
            cmd_o.pulse = 1'b1;
          end else if (status_i.period_end) begin
            cmd_o.period_done = 1'b1;
            state_d = ST_LOAD;
          end else begin
            cmd_o.tick_adv = 1'b1;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_fan) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.next_fan = 1'b1;
            state_d = ST_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

FILE: sv/ftrm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftrm_dp
// Datapath: config registers, pulse and period counters, serial divider,
// output register.
// ----------------------------------------------------------------------------
module ftrm_dp #(
  parameter int unsigned FAN_COUNT = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [ftrm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [ftrm_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 fan_i,
  input  ftrm_pkg::ctrl_cmd_t                  cmd_i,
  output ftrm_pkg::dp_status_t                 status_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 fan_id_o,
  output logic [ftrm_pkg::RPM_W-1:0]           rpm_o,
  output logic [ftrm_pkg::CNT_W-1:0]           pulse_count_o,
  output logic                                 last_o
);
  import ftrm_pkg::*;

  localparam int unsigned IDX_W = (FAN_COUNT > 1) ? $clog2(FAN_COUNT) : 1;

  // Configuration registers
  logic [TICK_W-1:0] period_ticks_q;
  logic [SEC_W-1:0]  period_seconds_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_ticks_q   <= PERIOD_TICKS_RST;
      period_seconds_q <= PERIOD_SECONDS_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_PERIOD_TICKS) begin
        period_ticks_q <= cfg_data_i[TICK_W-1:0];
      end else if (cfg_index_i == CFG_PERIOD_SECONDS) begin
        period_seconds_q <= cfg_data_i[SEC_W-1:0];
      end
    end
  end

  // Period counter; zero period acts as one, compare is reached-or-passed
  logic [TICK_W-1:0] tick_q;
  logic [TICK_W-1:0] limit;
  logic [TICK_W:0]   tick_next;

  assign limit     = (period_ticks_q == '0) ? TICK_W'(1) : period_ticks_q;
  assign tick_next = {1'b0, tick_q} + 1'b1;
  assign status_o.period_end = (tick_next >= {1'b0, limit});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else if (cmd_i.period_done) begin
      tick_q <= '0;
    end else if (cmd_i.tick_adv) begin
      tick_q <= tick_next[TICK_W-1:0];
    end
  end

  // Fan select
  logic [IDX_W-1:0] fan_idx_q;

  assign status_o.last_fan = (fan_idx_q == IDX_W'(FAN_COUNT - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_idx_q <= '0;
    end else if (cmd_i.period_done) begin
      fan_idx_q <= '0;
    end else if (cmd_i.next_fan) begin
      fan_idx_q <= fan_idx_q + 1'b1;
    end
  end

  // Pulse counters, saturating; pulses for missing fans are dropped
  logic [CNT_W-1:0] cnt_q [FAN_COUNT];
  logic [CNT_W-1:0] sel_cnt;

  assign sel_cnt = cnt_q[fan_idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FAN_COUNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < FAN_COUNT; i++) begin
        if (cmd_i.emit && (32'(fan_idx_q) == i)) begin
          cnt_q[i] <= '0;
        end else if (cmd_i.pulse && (32'(fan_i) == i) && (cnt_q[i] != '1)) begin
          cnt_q[i] <= cnt_q[i] + 1'b1;
        end
      end
    end
  end

  // Restoring divider: quotient shifts in where the dividend shifts out
  logic [DIVD_W-1:0] dividend;
  logic [CNT_W-2:0]  half;
  logic [SEC_W-1:0]  divisor;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [SEC_W-1:0]  rem_q, rem_d;
  logic [SEC_W:0]    trial;
  logic [SEC_W:0]    diff;

  assign half     = sel_cnt[CNT_W-1:1];
  assign dividend = (DIVD_W'(half) << 6) - (DIVD_W'(half) << 2);
  assign divisor  = (period_seconds_q == '0) ? SEC_W'(1) : period_seconds_q;
  assign trial    = {rem_q, quo_q[DIVD_W-1]};
  assign diff     = trial - {1'b0, divisor};

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    if (cmd_i.div_load) begin
      quo_d = dividend;
      rem_d = '0;
    end else if (cmd_i.div_step) begin
      if (trial >= {1'b0, divisor}) begin
        rem_d = diff[SEC_W-1:0];
        quo_d = {quo_q[DIVD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[SEC_W-1:0];
        quo_d = {quo_q[DIVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  // Output register
  logic             out_valid_q;
  logic [RPM_W-1:0] rpm_sat;

  assign rpm_sat = (quo_q[DIVD_W-1:RPM_W] != '0) ? '1 : quo_q[RPM_W-1:0];
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      fan_id_o      <= fan_idx_q[0];
      rpm_o         <= rpm_sat;
      pulse_count_o <= sel_cnt;
      last_o        <= status_o.last_fan;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
